/* hdl/jdd_pkg.sv */
// Shared types and constants of the joystick to differential drive mixer.
package jdd_pkg;

  // Configuration port.
  localparam int CFG_DATA_W = 8;

  typedef enum logic [1:0] {
    CFG_DEAD_ZONE  = 2'd0,
    CFG_FULL_SCALE = 2'd1,
    CFG_MIN_DUTY   = 2'd2,
    CFG_FULL_DUTY  = 2'd3
  } cfg_reg_t;

  localparam int DUTY_PCT_W = 7;

  localparam logic [7:0]            DEAD_ZONE_RESET  = 8'd43;
  localparam logic [7:0]            FULL_SCALE_RESET = 8'd128;
  localparam logic [DUTY_PCT_W-1:0] MIN_DUTY_RESET   = 7'd50;
  localparam logic [DUTY_PCT_W-1:0] FULL_DUTY_RESET  = 7'd95;

  // Sector bounds: tan(23 deg) and tan(68 deg) scaled by 10^10, truncated.
  localparam int              TAN_W      = 35;
  localparam int              TAN_PROD_W = TAN_W + 8;
  localparam logic [TAN_W-1:0] TAN_SCALE = 35'd10000000000;
  localparam logic [TAN_W-1:0] TAN_23    = 35'd4244748162;
  localparam logic [TAN_W-1:0] TAN_68    = 35'd24750868534;

  // Duty arithmetic.
  localparam int         DIV_QBITS   = 9;
  localparam logic [7:0] DUTY_MAX    = 8'd255;
  localparam logic [7:0] STOP_DUTY   = 8'd1;
  localparam logic [11:0] INNER_NUM  = 12'd9;
  localparam logic [15:0] RECIP_10   = 16'd52429;
  localparam int         RECIP_SHIFT = 19;

  // Motion sectors, counterclockwise from spin right.
  typedef enum logic [3:0] {
    SEC_STOP       = 4'd0,
    SEC_SPIN_RIGHT = 4'd1,
    SEC_FWD_RIGHT  = 4'd2,
    SEC_FWD        = 4'd3,
    SEC_FWD_LEFT   = 4'd4,
    SEC_SPIN_LEFT  = 4'd5,
    SEC_BACK_LEFT  = 4'd6,
    SEC_BACK       = 4'd7,
    SEC_BACK_RIGHT = 4'd8
  } sector_t;

  // One joystick sample.
  typedef struct packed {
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
  } in_t;

  // One motor command.
  typedef struct packed {
    logic [7:0] left_duty;
    logic       left_reverse;
    logic [7:0] right_duty;
    logic       right_reverse;
    logic [3:0] motion_sector;
  } out_t;

  // Per-sample flags that travel down the pipeline.
  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic past23;
    logic past68;
    logic live;
  } flag_t;

endpackage

/* hdl/joystick_to_differential_drive.sv */
// Pipelined joystick to differential drive mixer: radius, sector and motor duties.
//
//   Channel  Direction  Signals                         Moves
//   in       sink       in_valid  in_ready  in_data     one joystick sample (in_t)
//   out      source     out_valid out_ready out_data    one motor command (out_t)
//   cfg      sink       cfg_valid cfg_ready cfg_index   one register write request
//                       cfg_wdata
//
// A sample can enter every cycle unless a stalled output has backed up the pipeline;
// the depth comes from the square root (one root bit per stage) and the nine-stage divider.
// Reset is synchronous: registers take their defaults and the pipeline empties.
// Each stage moves on when it is empty or the next stage moves on, so bubbles close up
// and a stalled output holds its command while earlier stages keep filling.
// Configuration writes are always accepted.
module joystick_to_differential_drive #(
  parameter int RADIUS_FRACTION_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  jdd_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output jdd_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  jdd_pkg::cfg_reg_t                  cfg_index,
  input  logic [jdd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import jdd_pkg::*;

  localparam int FB = RADIUS_FRACTION_BITS;
  localparam int RW = 8 + FB;            // radius width
  localparam int VW = 2 * RW;            // radicand width
  localparam int NW = RW + DUTY_PCT_W;   // numerator width
  localparam int QB = DIV_QBITS;
  localparam int TW = RW + QB;           // divider trial width

  // Stage positions.
  localparam int P_ABS  = 0;
  localparam int P_SQ   = 1;
  localparam int P_RT0  = 2;
  localparam int P_OVR  = P_RT0 + RW;
  localparam int P_MUL  = P_OVR + 1;
  localparam int P_DCHK = P_MUL + 1;
  localparam int P_DV0  = P_DCHK + 1;
  localparam int P_DVL  = P_DV0 + QB - 1;
  localparam int P_DUTY = P_DVL + 1;
  localparam int P_OUT  = P_DUTY + 1;
  localparam int NSTG   = P_OUT + 1;

  // Configuration registers.
  logic [7:0]            dz_r;
  logic [7:0]            fs_r;
  logic [DUTY_PCT_W-1:0] mind_r;
  logic [DUTY_PCT_W-1:0] fulld_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r    <= DEAD_ZONE_RESET;
      fs_r    <= FULL_SCALE_RESET;
      mind_r  <= MIN_DUTY_RESET;
      fulld_r <= FULL_DUTY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEAD_ZONE:  dz_r    <= cfg_wdata;
        CFG_FULL_SCALE: fs_r    <= cfg_wdata;
        CFG_MIN_DUTY:   mind_r  <= cfg_wdata[DUTY_PCT_W-1:0];
        CFG_FULL_DUTY:  fulld_r <= cfg_wdata[DUTY_PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // From the registers; user must hold them still while samples are in flight, unenforced.
  logic                  den_pos;
  logic [7:0]            den;
  logic [RW-1:0]         div_d;
  logic                  diff_neg;
  logic [DUTY_PCT_W-1:0] diff_mag;
  logic [15:0]           dz_sq;
  logic [RW-1:0]         dz_fix;

  assign den_pos  = fs_r > dz_r;
  assign den      = fs_r - dz_r;
  assign div_d    = den_pos ? (RW'(den) << FB) : '0;
  assign diff_neg = mind_r > fulld_r;
  assign diff_mag = diff_neg ? (mind_r - fulld_r) : (fulld_r - mind_r);
  assign dz_sq    = 16'(dz_r) * 16'(dz_r);
  assign dz_fix   = RW'(dz_r) << FB;

  // Valid bits and the ripple of stage advances.
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] adv;

  for (genvar i = 0; i < NSTG; i++) begin : g_adv
    if (i == NSTG - 1) begin : g_last
      assign adv[i] = !vld_r[i] || out_ready;
    end else begin : g_mid
      assign adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign vld_nxt = (adv & {vld_r[NSTG-2:0], in_valid}) | (~adv & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NSTG-1];

  // Stage: magnitudes of the stick position.
  logic [7:0] ax_r;
  logic [7:0] ay_r;

  always_ff @(posedge clk) begin
    if (adv[P_ABS]) begin
      ax_r <= in_data.stick_x[7] ? 8'(-in_data.stick_x) : 8'(in_data.stick_x);
      ay_r <= in_data.stick_y[7] ? 8'(-in_data.stick_y) : 8'(in_data.stick_y);
    end
  end

  // Stage: squared radius.
  logic [15:0] sq_r;

  always_ff @(posedge clk) begin
    if (adv[P_SQ]) begin
      sq_r <= 16'(ax_r) * 16'(ax_r) + 16'(ay_r) * 16'(ay_r);
    end
  end

  // Flags: signs, sector bounds and the dead zone decision.
  flag_t flg_r [P_DUTY+1];

  for (genvar i = 0; i <= P_DUTY; i++) begin : g_flg
    flag_t nxt;
    if (i == P_ABS) begin : g_first
      always_comb begin
        nxt       = '0;
        nxt.x_neg = in_data.stick_x[7];
        nxt.y_neg = in_data.stick_y[7];
      end
    end else if (i == P_SQ) begin : g_angle
      always_comb begin
        nxt        = flg_r[i-1];
        nxt.past23 = (TAN_PROD_W'(ay_r) * TAN_PROD_W'(TAN_SCALE)) >
                     (TAN_PROD_W'(ax_r) * TAN_PROD_W'(TAN_23));
        nxt.past68 = (TAN_PROD_W'(ay_r) * TAN_PROD_W'(TAN_SCALE)) >
                     (TAN_PROD_W'(ax_r) * TAN_PROD_W'(TAN_68));
      end
    end else if (i == P_RT0) begin : g_dead
      always_comb begin
        nxt      = flg_r[i-1];
        nxt.live = sq_r >= dz_sq;
      end
    end else begin : g_carry
      assign nxt = flg_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (adv[i]) begin
        flg_r[i] <= nxt;
      end
    end
  end

  // Square root stages: one root bit per stage, restoring digit by digit.
  logic [RW+1:0] rt_rem_r  [RW];
  logic [RW-1:0] rt_root_r [RW];
  logic [VW-1:0] rt_v_r    [RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_rt
    logic [RW+1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [VW-1:0] v_in;
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic [RW+1:0] rem_nxt;
    logic [RW-1:0] root_nxt;

    if (k == 0) begin : g_src0
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = VW'(sq_r) << (2 * FB);
    end else begin : g_srck
      assign rem_in  = rt_rem_r[k-1];
      assign root_in = rt_root_r[k-1];
      assign v_in    = rt_v_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[RW-1:0], v_in[VW-1 -: 2]};
      trial  = {root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (adv[P_RT0+k]) begin
        rt_rem_r[k]  <= rem_nxt;
        rt_root_r[k] <= root_nxt;
      end
    end

    if (k < RW - 1) begin : g_vsh
      always_ff @(posedge clk) begin
        if (adv[P_RT0+k]) begin
          rt_v_r[k] <= v_in << 2;
        end
      end
    end
  end

  // Stage: radius beyond the dead zone edge.
  logic [RW-1:0] over_r;

  always_ff @(posedge clk) begin
    if (adv[P_OVR]) begin
      over_r <= rt_root_r[RW-1] - dz_fix;
    end
  end

  // Stage: duty span times the excess radius.
  logic [NW-1:0] num_r;

  always_ff @(posedge clk) begin
    if (adv[P_MUL]) begin
      num_r <= NW'(over_r) * NW'(diff_mag);
    end
  end

  // Stage: quotients beyond nine bits saturate.
  logic [NW-1:0] chk_rem_r;
  logic          chk_sat_r;

  always_ff @(posedge clk) begin
    if (adv[P_DCHK]) begin
      chk_rem_r <= num_r;
      chk_sat_r <= TW'(num_r) >= (TW'(div_d) << QB);
    end
  end

  // Divider stages: one quotient bit per stage, most significant first.
  logic [NW-1:0] dv_rem_r [QB];
  logic [QB-1:0] dv_q_r   [QB];
  logic          dv_sat_r [QB];

  for (genvar j = 0; j < QB; j++) begin : g_dv
    localparam int B = QB - 1 - j;
    logic [NW-1:0] rem_in;
    logic [QB-1:0] q_in;
    logic          sat_in;
    logic [TW-1:0] trial;
    logic [NW-1:0] rem_nxt;
    logic [QB-1:0] q_nxt;

    if (j == 0) begin : g_src0
      assign rem_in = chk_rem_r;
      assign q_in   = '0;
      assign sat_in = chk_sat_r;
    end else begin : g_srcj
      assign rem_in = dv_rem_r[j-1];
      assign q_in   = dv_q_r[j-1];
      assign sat_in = dv_sat_r[j-1];
    end

    always_comb begin
      trial = TW'(div_d) << B;
      if (TW'(rem_in) >= trial) begin
        rem_nxt = rem_in - NW'(trial);
        q_nxt   = q_in | (QB'(1) << B);
      end else begin
        rem_nxt = rem_in;
        q_nxt   = q_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[P_DV0+j]) begin
        dv_rem_r[j] <= rem_nxt;
        dv_q_r[j]   <= q_nxt;
        dv_sat_r[j] <= sat_in;
      end
    end
  end

  // Stage: duty from the quotient, rounded toward minus infinity and clamped.
  logic [QB-1:0] q_sel;
  logic [9:0]    up_sum;
  logic [9:0]    dn_sub;
  logic [7:0]    duty_nxt;
  logic [7:0]    duty_r;

  always_comb begin
    q_sel  = dv_sat_r[QB-1] ? '1 : dv_q_r[QB-1];
    up_sum = 10'(mind_r) + 10'(q_sel);
    dn_sub = 10'(q_sel) + 10'((dv_rem_r[QB-1] != '0) && !dv_sat_r[QB-1]);
    if (!den_pos) begin
      duty_nxt = 8'(fulld_r);
    end else if (!diff_neg) begin
      duty_nxt = (up_sum > 10'(DUTY_MAX)) ? DUTY_MAX : up_sum[7:0];
    end else if (dn_sub >= 10'(mind_r)) begin
      duty_nxt = '0;
    end else begin
      duty_nxt = 8'(10'(mind_r) - dn_sub);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[P_DUTY]) begin
      duty_r <= duty_nxt;
    end
  end

  // Output stage: sector, inner wheel duty and the motor command.
  flag_t       fo;
  logic [11:0] prod9;
  logic [7:0]  inner;
  sector_t     sec;
  out_t        out_nxt;
  out_t        out_r;

  always_comb begin
    fo    = flg_r[P_DUTY];
    prod9 = 12'(duty_r) * INNER_NUM;
    inner = 8'((28'(prod9) * 28'(RECIP_10)) >> RECIP_SHIFT);

    if (!fo.live) begin
      sec = SEC_STOP;
    end else if (!fo.x_neg) begin
      sec = !fo.past23 ? SEC_SPIN_RIGHT :
            !fo.past68 ? (!fo.y_neg ? SEC_FWD_RIGHT : SEC_BACK_RIGHT) :
                         (!fo.y_neg ? SEC_FWD : SEC_BACK);
    end else begin
      sec = !fo.past23 ? SEC_SPIN_LEFT :
            !fo.past68 ? (!fo.y_neg ? SEC_FWD_LEFT : SEC_BACK_LEFT) :
                         (!fo.y_neg ? SEC_FWD : SEC_BACK);
    end

    out_nxt.left_duty     = duty_r;
    out_nxt.right_duty    = duty_r;
    out_nxt.left_reverse  = 1'b0;
    out_nxt.right_reverse = 1'b0;
    out_nxt.motion_sector = sec;
    unique case (sec)
      SEC_STOP: begin
        out_nxt.left_duty  = STOP_DUTY;
        out_nxt.right_duty = STOP_DUTY;
      end
      SEC_SPIN_RIGHT: out_nxt.right_reverse = 1'b1;
      SEC_FWD_RIGHT:  out_nxt.right_duty    = inner;
      SEC_FWD: ;
      SEC_FWD_LEFT:   out_nxt.left_duty     = inner;
      SEC_SPIN_LEFT:  out_nxt.left_reverse  = 1'b1;
      SEC_BACK_LEFT: begin
        out_nxt.left_duty     = inner;
        out_nxt.left_reverse  = 1'b1;
        out_nxt.right_reverse = 1'b1;
      end
      SEC_BACK: begin
        out_nxt.left_reverse  = 1'b1;
        out_nxt.right_reverse = 1'b1;
      end
      SEC_BACK_RIGHT: begin
        out_nxt.right_duty    = inner;
        out_nxt.left_reverse  = 1'b1;
        out_nxt.right_reverse = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[P_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // The number of samples in flight changes only by requests taken and commands delivered.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $countones(vld_r) == $past($countones(vld_r)) +
      int'($past(in_valid && in_ready)) - int'($past(out_valid && out_ready)))
    else $error("pipeline lost or repeated a sample");

  // A finished square root leaves a remainder no larger than twice the root.
  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[P_RT0+RW-1] |-> rt_rem_r[RW-1] <= {1'b0, rt_root_r[RW-1], 1'b0})
    else $error("square root remainder out of range");

  // An unsaturated division leaves a remainder below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[P_DVL] && den_pos && !dv_sat_r[QB-1] |->
      dv_rem_r[QB-1] < {{(NW-RW){1'b0}}, div_d})
    else $error("divider remainder not below divisor");

  // A stop command drives both motors forward at the stop duty.
  a_stop_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_r.motion_sector == SEC_STOP |->
      out_r.left_duty == STOP_DUTY && out_r.right_duty == STOP_DUTY &&
      !out_r.left_reverse && !out_r.right_reverse)
    else $error("malformed stop command");

  // On a left arc the inner left wheel never outruns the right wheel.
  a_left_arc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_r.motion_sector == SEC_FWD_LEFT ||
                  out_r.motion_sector == SEC_BACK_LEFT) |->
      out_r.left_duty <= out_r.right_duty)
    else $error("inner wheel faster than outer wheel");

endmodule

/* verif/tb_joystick_to_differential_drive.sv */
// Self-checking testbench for the joystick to differential drive mixer.
module tb_joystick_to_differential_drive;
  import jdd_pkg::*;

  localparam int FRAC_BITS = 8;
  localparam int PIPE_LATENCY = FRAC_BITS + 24;
  localparam int STALL_LIMIT = 4000;

  // Sector bounds as tangents scaled by 10^10, truncated.
  localparam longint unsigned TAN_UNIT = 64'd10000000000;
  localparam longint unsigned TAN_LOW_BOUND = 64'd4244748162;
  localparam longint unsigned TAN_HIGH_BOUND = 64'd24750868534;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_t cfg_index = CFG_DEAD_ZONE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Register copies that the duty predictor works from.
  logic [7:0] dead_zone_q = DEAD_ZONE_RESET;
  logic [7:0] full_scale_q = FULL_SCALE_RESET;
  logic [DUTY_PCT_W-1:0] min_duty_q = MIN_DUTY_RESET;
  logic [DUTY_PCT_W-1:0] full_duty_q = FULL_DUTY_RESET;

  out_t pending_cmds[$];
  out_t want_cmd;
  logic idle_en = 1'b1;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int error_count = 0;
  int samples_sent = 0;
  int commands_checked = 0;
  int settings_count = 1;

  joystick_to_differential_drive #(
    .RADIUS_FRACTION_BITS(FRAC_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fixed-point radius: the largest value whose square does not exceed the scaled sum.
  function automatic longint unsigned stick_radius(longint unsigned scaled_sq);
    longint unsigned acc;
    longint unsigned trial;
    acc = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = acc | (64'd1 << b);
      if (trial * trial <= scaled_sq) begin
        acc = trial;
      end
    end
    return acc;
  endfunction

  // Duty interpolated between the dead zone edge and full scale, floored and saturated.
  function automatic int unsigned interp_duty(longint unsigned radius);
    longint span;
    longint gain;
    longint excess;
    longint num;
    longint dnm;
    longint quo;
    longint total;
    span = longint'(full_scale_q) - longint'(dead_zone_q);
    if (span <= 0) begin
      total = longint'(full_duty_q);
    end else begin
      gain = longint'(full_duty_q) - longint'(min_duty_q);
      excess = longint'(radius) - (longint'(dead_zone_q) << FRAC_BITS);
      num = gain * excess;
      dnm = span << FRAC_BITS;
      if (num >= 0) begin
        quo = num / dnm;
      end else begin
        quo = -((-num + dnm - 1) / dnm);
      end
      total = longint'(min_duty_q) + quo;
    end
    if (total < 0) begin
      total = 0;
    end
    if (total > 255) begin
      total = 255;
    end
    return int'(total);
  endfunction

  // Motor command for one sample under the current register settings.
  function automatic out_t mix_command(in_t s);
    out_t cmd;
    int xi;
    int yi;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned radius;
    int unsigned duty;
    int unsigned inner;
    logic past_low;
    logic past_high;
    sector_t sec;
    xi = s.stick_x;
    yi = s.stick_y;
    ax = longint'((xi < 0) ? -xi : xi);
    ay = longint'((yi < 0) ? -yi : yi);
    radius = stick_radius((ax * ax + ay * ay) << (2 * FRAC_BITS));
    cmd.left_duty = STOP_DUTY;
    cmd.right_duty = STOP_DUTY;
    cmd.left_reverse = 1'b0;
    cmd.right_reverse = 1'b0;
    cmd.motion_sector = SEC_STOP;
    if (radius >= (longint'(dead_zone_q) << FRAC_BITS)) begin
      duty = interp_duty(radius);
      inner = (duty * 9) / 10;
      past_low = (ay * TAN_UNIT) > (ax * TAN_LOW_BOUND);
      past_high = (ay * TAN_UNIT) > (ax * TAN_HIGH_BOUND);
      // Pick the sector from the side, the bound crossed and the half plane.
      if (past_high) begin
        sec = (yi >= 0) ? SEC_FWD : SEC_BACK;
      end else if (past_low) begin
        if (xi >= 0) begin
          sec = (yi >= 0) ? SEC_FWD_RIGHT : SEC_BACK_RIGHT;
        end else begin
          sec = (yi >= 0) ? SEC_FWD_LEFT : SEC_BACK_LEFT;
        end
      end else begin
        sec = (xi >= 0) ? SEC_SPIN_RIGHT : SEC_SPIN_LEFT;
      end
      cmd.left_duty = duty[7:0];
      cmd.right_duty = duty[7:0];
      cmd.motion_sector = sec;
      // Arcs slow the inner wheel; the back half runs both wheels in reverse.
      case (sec)
        SEC_SPIN_RIGHT: cmd.right_reverse = 1'b1;
        SEC_FWD_RIGHT: cmd.right_duty = inner[7:0];
        SEC_FWD_LEFT: cmd.left_duty = inner[7:0];
        SEC_SPIN_LEFT: cmd.left_reverse = 1'b1;
        SEC_BACK_LEFT: begin
          cmd.left_duty = inner[7:0];
          cmd.left_reverse = 1'b1;
          cmd.right_reverse = 1'b1;
        end
        SEC_BACK: begin
          cmd.left_reverse = 1'b1;
          cmd.right_reverse = 1'b1;
        end
        SEC_BACK_RIGHT: begin
          cmd.right_duty = inner[7:0];
          cmd.left_reverse = 1'b1;
          cmd.right_reverse = 1'b1;
        end
        default: ;
      endcase
    end
    return cmd;
  endfunction

  function automatic in_t make_sample(int x, int y);
    in_t s;
    s.stick_x = x[7:0];
    s.stick_y = y[7:0];
    return s;
  endfunction

  // Random sample: mostly uniform, some near the dead zone edge, some on axes, diagonals and sector bounds.
  function automatic in_t pick_sample();
    int unsigned mode;
    int lim;
    int a;
    int b;
    mode = $urandom_range(0, 19);
    if (mode < 12) begin
      return make_sample($urandom_range(0, 255), $urandom_range(0, 255));
    end else if (mode < 16) begin
      lim = (dead_zone_q > 119) ? 127 : dead_zone_q + 8;
      return make_sample(int'($urandom_range(0, 2 * lim)) - lim,
                         int'($urandom_range(0, 2 * lim)) - lim);
    end else begin
      a = $urandom_range(1, 128);
      case ($urandom_range(0, 3))
        0: b = 0;
        1: b = a;
        2: b = (a * 4245) / 10000 + $urandom_range(0, 1);
        default: begin
          a = $urandom_range(1, 51);
          b = (a * 24751) / 10000 + $urandom_range(0, 1);
        end
      endcase
      if (b > 128) begin
        b = 128;
      end
      if ($urandom_range(0, 1) == 1) begin
        a = -a;
      end
      if ($urandom_range(0, 1) == 1) begin
        b = -b;
      end
      if (a == 128) begin
        a = 127;
      end
      if (b == 128) begin
        b = 127;
      end
      return ($urandom_range(0, 1) == 1) ? make_sample(a, b) : make_sample(b, a);
    end
  endfunction

  // Send one sample request and record the command it must produce.
  task automatic send_sample(in_t s);
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    pending_cmds.push_back(mix_command(s));
    samples_sent++;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic run_samples(int count);
    for (int i = 0; i < count; i++) begin
      send_sample(pick_sample());
    end
  endtask

  // Let every outstanding command drain before touching the registers.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DEAD_ZONE: dead_zone_q = value;
      CFG_FULL_SCALE: full_scale_q = value;
      CFG_MIN_DUTY: min_duty_q = value[DUTY_PCT_W-1:0];
      CFG_FULL_DUTY: full_duty_q = value[DUTY_PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [7:0] dz, logic [7:0] fr, logic [7:0] mn,
                                logic [7:0] fd);
    drain_pipeline();
    write_reg(CFG_DEAD_ZONE, dz);
    write_reg(CFG_FULL_SCALE, fr);
    write_reg(CFG_MIN_DUTY, mn);
    write_reg(CFG_FULL_DUTY, fd);
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  // Reset settings: stick extremes, every sector, dead zone edge and sector bounds.
  task automatic test_directed_defaults();
    send_sample(make_sample(0, 0));
    send_sample(make_sample(127, 127));
    send_sample(make_sample(-128, -128));
    send_sample(make_sample(-128, 127));
    send_sample(make_sample(127, -128));
    send_sample(make_sample(127, 0));
    send_sample(make_sample(-128, 0));
    send_sample(make_sample(0, 127));
    send_sample(make_sample(0, -128));
    send_sample(make_sample(100, 60));
    send_sample(make_sample(-100, 60));
    send_sample(make_sample(-100, -60));
    send_sample(make_sample(100, -60));
    send_sample(make_sample(43, 0));
    send_sample(make_sample(42, 0));
    send_sample(make_sample(30, 30));
    send_sample(make_sample(31, -31));
    send_sample(make_sample(106, 45));
    send_sample(make_sample(33, 14));
    send_sample(make_sample(40, 99));
    send_sample(make_sample(-51, -127));
    send_sample(make_sample(0, -1));
    send_sample(make_sample(-1, -1));
    run_samples(100);
  endtask

  // Extreme register settings, including values masked to their widths.
  task automatic test_config_extremes();
    apply_settings(8'd0, 8'd255, 8'd0, 8'd100);
    send_sample(make_sample(0, 0));
    run_samples(120);
    apply_settings(8'd181, 8'd1, 8'd100, 8'd0);
    run_samples(120);
    apply_settings(8'd0, 8'd1, 8'd0, 8'hFF);
    run_samples(120);
    apply_settings(8'd255, 8'd255, 8'hFF, 8'd0);
    run_samples(120);
    apply_settings(8'd10, 8'd100, 8'd100, 8'd0);
    run_samples(120);
    apply_settings(8'd0, 8'd0, 8'd30, 8'd60);
    send_sample(make_sample(0, 0));
    run_samples(120);
  endtask

  // Random register settings, each followed by random samples.
  task automatic test_random_settings();
    for (int k = 0; k < 4; k++) begin
      apply_settings(8'($urandom_range(0, 181)), 8'($urandom_range(1, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_samples(120);
    end
  endtask

  // Back-to-back samples with the result side always ready.
  task automatic test_steady_stream();
    apply_settings(DEAD_ZONE_RESET, FULL_SCALE_RESET, 8'(MIN_DUTY_RESET),
                   8'(FULL_DUTY_RESET));
    idle_en <= 1'b0;
    run_samples(380);
  endtask

  // Result side: random stall bursts while idling is enabled.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted command with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        $error("motor command with no sample pending: %h", out_data);
        error_count++;
      end else begin
        want_cmd = pending_cmds.pop_front();
        commands_checked++;
        if (out_data.left_duty !== want_cmd.left_duty) begin
          $error("left_duty: expected %0d, actual %0d", want_cmd.left_duty,
                 out_data.left_duty);
          error_count++;
        end
        if (out_data.left_reverse !== want_cmd.left_reverse) begin
          $error("left_reverse: expected %0d, actual %0d", want_cmd.left_reverse,
                 out_data.left_reverse);
          error_count++;
        end
        if (out_data.right_duty !== want_cmd.right_duty) begin
          $error("right_duty: expected %0d, actual %0d", want_cmd.right_duty,
                 out_data.right_duty);
          error_count++;
        end
        if (out_data.right_reverse !== want_cmd.right_reverse) begin
          $error("right_reverse: expected %0d, actual %0d", want_cmd.right_reverse,
                 out_data.right_reverse);
          error_count++;
        end
        if (out_data.motion_sector !== want_cmd.motion_sector) begin
          $error("motion_sector: expected %0d, actual %0d", want_cmd.motion_sector,
                 out_data.motion_sector);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no request moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("joystick_to_differential_drive test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_defaults();
    test_config_extremes();
    test_random_settings();
    test_steady_stream();
    drain_pipeline();
    $display("Checked %0d motor commands from %0d joystick samples over %0d register settings.",
             commands_checked, samples_sent, settings_count);
    $display("Stick extremes, dead zone edges, sector bounds and duty saturation were exercised.");
    if (error_count == 0 && pending_cmds.size() == 0) begin
      $display("joystick_to_differential_drive test passed");
    end else begin
      $display("joystick_to_differential_drive test failed");
    end
    $finish;
  end

endmodule
